// ===== rtl/falling_sand_grid_update_core_macros.svh =====
// assertion macros for the falling sand grid update core
`ifndef FALLING_SAND_GRID_UPDATE_CORE_MACROS_SVH
`define FALLING_SAND_GRID_UPDATE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FSGU_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fsgu: same-cycle check failed");
`define FSGU_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fsgu: next-cycle check failed");
`else
`define FSGU_ASSERT_IMP(label, ante, cons)
`define FSGU_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== rtl/fsgu_pkg.sv =====
// shared types and constants for the falling sand grid update core
`timescale 1ns / 1ps

package fsgu_pkg;

   localparam int CELL_W  = 8;
   localparam int COUNT_W = 13;
   localparam int SEED_W  = 32;
   localparam int CSR_W   = 32;
   localparam int PADDR_W = 3;

   localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
   localparam logic [COUNT_W-1:0] LIMIT_RESET = 13'd2048;
   localparam logic [SEED_W-1:0]  SEED_RESET  = 32'd1;

   // register index, taken from paddr bit 2
   localparam logic CSR_FILL_LIMIT = 1'b0;
   localparam logic CSR_SEED       = 1'b1;

   typedef enum logic [1:0] {
      OP_PLACE   = 2'd0,
      OP_SUBSTEP = 2'd1,
      OP_DRAIN   = 2'd2,
      OP_READ    = 2'd3
   } op_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_PL_CHK,
      ST_PL_LIMIT,
      ST_RD_CAP,
      ST_SS_CUR,
      ST_SS_G,
      ST_SS_LOW,
      ST_SS_LL,
      ST_SS_LC,
      ST_SS_LR,
      ST_SS_RC,
      ST_SS_CLR,
      ST_SS_NEXT,
      ST_DR_CELL,
      ST_DR_CNT,
      ST_DR_WR,
      ST_DR_NEXT,
      ST_DR_FIN,
      ST_DONE
   } fsgu_state_type;

   typedef enum logic [3:0] {
      AS_CLEAR,
      AS_PLACE,
      AS_READ,
      AS_CUR,
      AS_LOW,
      AS_LOW_L,
      AS_CUR_L,
      AS_LOW_R,
      AS_CUR_R,
      AS_DIAG,
      AS_ABOVE
   } addr_sel_type;

   typedef enum logic [1:0] {
      WD_ZERO,
      WD_HUE,
      WD_GRAIN,
      WD_RDATA
   } wd_sel_type;

   typedef struct packed {
      logic         wr_en;
      addr_sel_type addr_sel;
      wd_sel_type   wd_sel;
      logic         latch_req;
      logic         cap_value;
      logic         load_g;
      logic         save_ll;
      logic         save_lc;
      logic         save_lr;
      logic         rng_step;
      logic         cnt_inc;
      logic         cnt_dec;
      logic         set_drain;
      logic         clr_drain;
      logic         set_placed;
      logic         toggle_sweep;
      logic         init_substep;
      logic         init_drain;
      logic         step_cell;
      logic         step_clear;
      logic         load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      op_type op;
      logic   drain;
      logic   col_ok;
      logic   read_ok;
      logic   rdata_zero;
      logic   left_free;
      logic   right_free;
      logic   row_zero;
      logic   row_bottom;
      logic   col_last;
      logic   clr_last;
      logic   count_zero;
      logic   over_limit;
   } dp_status_type;

endpackage

// ===== rtl/fsgu_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module fsgu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/fsgu_ctrl.sv =====
// sequencing state machine for the falling sand grid update core
`timescale 1ns / 1ps

module fsgu_ctrl
   import fsgu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          rsp_free,
   input  dp_status_type sts,
   output ctrl_cmd_type  cmd
);

   fsgu_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.wr_en      = 1'b1;
            cmd.addr_sel   = AS_CLEAR;
            cmd.wd_sel     = WD_ZERO;
            cmd.step_clear = 1'b1;
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (sts.op)
               OP_PLACE: begin
                  if (sts.drain) begin
                     state_in = ST_DONE;
                  end else if (!sts.col_ok) begin
                     state_in = ST_PL_LIMIT;
                  end else begin
                     cmd.addr_sel = AS_PLACE;
                     state_in     = ST_PL_CHK;
                  end
               end
               OP_READ: begin
                  if (sts.read_ok) begin
                     cmd.addr_sel = AS_READ;
                     state_in     = ST_RD_CAP;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               OP_SUBSTEP: begin
                  cmd.toggle_sweep = 1'b1;
                  cmd.init_substep = 1'b1;
                  state_in         = ST_SS_CUR;
               end
               OP_DRAIN: begin
                  if (sts.drain) begin
                     cmd.init_drain = 1'b1;
                     state_in       = ST_DR_CELL;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_PL_CHK: begin
            if (sts.rdata_zero) begin
               cmd.wr_en      = 1'b1;
               cmd.addr_sel   = AS_PLACE;
               cmd.wd_sel     = WD_HUE;
               cmd.cnt_inc    = 1'b1;
               cmd.set_placed = 1'b1;
            end
            state_in = ST_PL_LIMIT;
         end
         ST_PL_LIMIT: begin
            cmd.set_drain = sts.over_limit;
            state_in      = ST_DONE;
         end
         ST_RD_CAP: begin
            cmd.cap_value = 1'b1;
            state_in      = ST_DONE;
         end
         ST_SS_CUR: begin
            cmd.addr_sel = AS_CUR;
            state_in     = ST_SS_G;
         end
         ST_SS_G: begin
            if (sts.rdata_zero) begin
               state_in = ST_SS_NEXT;
            end else begin
               cmd.load_g   = 1'b1;
               cmd.addr_sel = AS_LOW;
               state_in     = ST_SS_LOW;
            end
         end
         ST_SS_LOW: begin
            if (sts.rdata_zero) begin
               cmd.wr_en    = 1'b1;
               cmd.addr_sel = AS_LOW;
               cmd.wd_sel   = WD_GRAIN;
               state_in     = ST_SS_CLR;
            end else begin
               cmd.addr_sel = AS_LOW_L;
               state_in     = ST_SS_LL;
            end
         end
         ST_SS_LL: begin
            cmd.save_ll  = 1'b1;
            cmd.addr_sel = AS_CUR_L;
            state_in     = ST_SS_LC;
         end
         ST_SS_LC: begin
            cmd.save_lc  = 1'b1;
            cmd.addr_sel = AS_LOW_R;
            state_in     = ST_SS_LR;
         end
         ST_SS_LR: begin
            cmd.save_lr  = 1'b1;
            cmd.addr_sel = AS_CUR_R;
            state_in     = ST_SS_RC;
         end
         ST_SS_RC: begin
            if (sts.left_free || sts.right_free) begin
               cmd.wr_en    = 1'b1;
               cmd.addr_sel = AS_DIAG;
               cmd.wd_sel   = WD_GRAIN;
               cmd.rng_step = sts.left_free && sts.right_free;
               state_in     = ST_SS_CLR;
            end else begin
               state_in = ST_SS_NEXT;
            end
         end
         ST_SS_CLR: begin
            cmd.wr_en    = 1'b1;
            cmd.addr_sel = AS_CUR;
            cmd.wd_sel   = WD_ZERO;
            state_in     = ST_SS_NEXT;
         end
         ST_SS_NEXT: begin
            cmd.step_cell = 1'b1;
            if (sts.col_last && sts.row_zero) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SS_CUR;
            end
         end
         ST_DR_CELL: begin
            if (sts.row_bottom) begin
               cmd.addr_sel = AS_CUR;
               state_in     = ST_DR_CNT;
            end else if (sts.row_zero) begin
               cmd.wr_en    = 1'b1;
               cmd.addr_sel = AS_CUR;
               cmd.wd_sel   = WD_ZERO;
               state_in     = ST_DR_NEXT;
            end else begin
               cmd.addr_sel = AS_ABOVE;
               state_in     = ST_DR_WR;
            end
         end
         ST_DR_CNT: begin
            cmd.cnt_dec  = !sts.rdata_zero && !sts.count_zero;
            cmd.addr_sel = AS_ABOVE;
            state_in     = ST_DR_WR;
         end
         ST_DR_WR: begin
            cmd.wr_en    = 1'b1;
            cmd.addr_sel = AS_CUR;
            cmd.wd_sel   = WD_RDATA;
            state_in     = ST_DR_NEXT;
         end
         ST_DR_NEXT: begin
            cmd.step_cell = 1'b1;
            if (sts.col_last && sts.row_zero) begin
               state_in = ST_DR_FIN;
            end else begin
               state_in = ST_DR_CELL;
            end
         end
         ST_DR_FIN: begin
            cmd.clr_drain = sts.count_zero;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/fsgu_datapath.sv =====
// grid memory, scan counters, random generator and grain bookkeeping
`timescale 1ns / 1ps

module fsgu_datapath
   import fsgu_pkg::*;
#(
   parameter int GRID_WIDTH  = 64,
   parameter int GRID_HEIGHT = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  ctrl_cmd_type       cmd,
   output dp_status_type      sts,
   input  logic [1:0]         req_op,
   input  logic [5:0]         req_column,
   input  logic [5:0]         req_grid_row,
   input  logic [CELL_W-1:0]  req_hue,
   input  logic [COUNT_W-1:0] drain_limit,
   input  logic               seed_load,
   input  logic [SEED_W-1:0]  seed_value,
   output logic [CELL_W-1:0]  value,
   output logic [COUNT_W-1:0] count,
   output logic               drain,
   output logic               placed
);

   localparam int CELLS  = GRID_WIDTH * GRID_HEIGHT;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int COL_W  = $clog2(GRID_WIDTH);
   localparam int ROW_W  = $clog2(GRID_HEIGHT);
   localparam logic [ADDR_W-1:0] W_A      = ADDR_W'(GRID_WIDTH);
   localparam logic [ADDR_W-1:0] LAST_A   = ADDR_W'(CELLS - 1);
   localparam logic [COL_W-1:0]  COL_LAST = COL_W'(GRID_WIDTH - 1);
   localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(GRID_HEIGHT - 1);
   localparam logic [ROW_W-1:0]  ROW_INIT = ROW_W'(GRID_HEIGHT - 2);

   op_type              op_ff;
   logic [5:0]          col_req_ff;
   logic [5:0]          row_req_ff;
   logic [CELL_W-1:0]   hue_ff;
   logic [ROW_W-1:0]    row_ff;
   logic [COL_W-1:0]    idx_ff;
   logic [ADDR_W-1:0]   clr_addr_ff;
   logic [CELL_W-1:0]   g_ff;
   logic                ll_ff, lc_ff, lr_ff;
   logic [SEED_W-1:0]   rng_ff, rng_in;
   logic                sweep_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic                drain_ff;
   logic                placed_ff;
   logic [CELL_W-1:0]   value_ff;

   logic [COL_W-1:0]    x;
   logic [ADDR_W-1:0]   cur_addr, low_addr, addr;
   logic [CELL_W-1:0]   rdata, wdata;
   logic                rdata_zero, left_free, right_free, go_right;
   logic [SEED_W-1:0]   s1, s2;

   // scan column runs right to left on reversed substep passes
   assign x = (op_ff == OP_SUBSTEP && sweep_ff) ? COL_LAST - idx_ff : idx_ff;

   assign cur_addr = ADDR_W'(ADDR_W'(row_ff) * W_A) + ADDR_W'(x);
   assign low_addr = cur_addr + W_A;

   assign rdata_zero = (rdata == '0);
   assign left_free  = (x != '0) && ll_ff && lc_ff;
   assign right_free = (x != COL_LAST) && lr_ff && rdata_zero;

   // xorshift32 step
   assign s1     = rng_ff ^ (rng_ff << 13);
   assign s2     = s1 ^ (s1 >> 17);
   assign rng_in = s2 ^ (s2 << 5);

   assign go_right = (left_free && right_free) ? rng_in[0] : right_free;

   always_comb begin
      unique case (cmd.addr_sel)
         AS_CLEAR: addr = clr_addr_ff;
         AS_PLACE: addr = ADDR_W'(col_req_ff);
         AS_READ:  addr = ADDR_W'(ADDR_W'(row_req_ff) * W_A) + ADDR_W'(col_req_ff);
         AS_CUR:   addr = cur_addr;
         AS_LOW:   addr = low_addr;
         AS_LOW_L: addr = low_addr - ADDR_W'(1);
         AS_CUR_L: addr = cur_addr - ADDR_W'(1);
         AS_LOW_R: addr = low_addr + ADDR_W'(1);
         AS_CUR_R: addr = cur_addr + ADDR_W'(1);
         AS_DIAG:  addr = go_right ? low_addr + ADDR_W'(1) : low_addr - ADDR_W'(1);
         AS_ABOVE: addr = cur_addr - W_A;
         default:  addr = cur_addr;
      endcase
   end

   always_comb begin
      unique case (cmd.wd_sel)
         WD_ZERO:  wdata = '0;
         WD_HUE:   wdata = (hue_ff == '0) ? CELL_W'(1) : hue_ff;
         WD_GRAIN: wdata = g_ff;
         WD_RDATA: wdata = rdata;
         default:  wdata = '0;
      endcase
   end

   fsgu_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_grid (
      .clock (clock),
      .wr_en (cmd.wr_en),
      .waddr (addr),
      .wdata (wdata),
      .raddr (addr),
      .rdata (rdata)
   );

   // request fields and scan scratch
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff      <= op_type'(req_op);
         col_req_ff <= req_column;
         row_req_ff <= req_grid_row;
         hue_ff     <= req_hue;
      end
      if (cmd.init_substep) begin
         row_ff <= ROW_INIT;
         idx_ff <= '0;
      end else if (cmd.init_drain) begin
         row_ff <= ROW_LAST;
         idx_ff <= '0;
      end else if (cmd.step_cell) begin
         if (idx_ff == COL_LAST) begin
            idx_ff <= '0;
            row_ff <= row_ff - ROW_W'(1);
         end else begin
            idx_ff <= idx_ff + COL_W'(1);
         end
      end
      if (cmd.load_g)  g_ff  <= rdata;
      if (cmd.save_ll) ll_ff <= rdata_zero;
      if (cmd.save_lc) lc_ff <= rdata_zero;
      if (cmd.save_lr) lr_ff <= rdata_zero;
      if (cmd.latch_req) begin
         value_ff <= '0;
      end else if (cmd.cap_value) begin
         value_ff <= rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         rng_ff      <= SEED_RESET;
         sweep_ff    <= 1'b0;
         count_ff    <= '0;
         drain_ff    <= 1'b0;
         placed_ff   <= 1'b0;
      end else begin
         if (cmd.step_clear) clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         if (seed_load) begin
            rng_ff <= (seed_value == '0) ? SEED_RESET : seed_value;
         end else if (cmd.rng_step) begin
            rng_ff <= rng_in;
         end
         if (cmd.toggle_sweep) sweep_ff <= !sweep_ff;
         if (cmd.cnt_inc && count_ff != COUNT_MAX) begin
            count_ff <= count_ff + COUNT_W'(1);
         end else if (cmd.cnt_dec) begin
            count_ff <= count_ff - COUNT_W'(1);
         end
         if (cmd.set_drain) begin
            drain_ff <= 1'b1;
         end else if (cmd.clr_drain) begin
            drain_ff <= 1'b0;
         end
         if (cmd.latch_req) begin
            placed_ff <= 1'b0;
         end else if (cmd.set_placed) begin
            placed_ff <= 1'b1;
         end
      end
   end

   always_comb begin
      sts            = '0;
      sts.op         = op_ff;
      sts.drain      = drain_ff;
      sts.col_ok     = int'(col_req_ff) < GRID_WIDTH;
      sts.read_ok    = (int'(col_req_ff) < GRID_WIDTH) && (int'(row_req_ff) < GRID_HEIGHT);
      sts.rdata_zero = rdata_zero;
      sts.left_free  = left_free;
      sts.right_free = right_free;
      sts.row_zero   = (row_ff == '0);
      sts.row_bottom = (row_ff == ROW_LAST);
      sts.col_last   = (idx_ff == COL_LAST);
      sts.clr_last   = (clr_addr_ff == LAST_A);
      sts.count_zero = (count_ff == '0);
      sts.over_limit = (count_ff > drain_limit);
   end

   assign value  = value_ff;
   assign count  = count_ff;
   assign drain  = drain_ff;
   assign placed = placed_ff;

endmodule

// ===== rtl/falling_sand_grid_update_core.sv =====
// top level of the falling sand grid update core
// throughput: one word at a time; the grid ram, with one shared read and write address, sets the pace
// reset: synchronous, clears control state, then a clearing pass zeroes the grid
//   before the first word is taken
`timescale 1ns / 1ps

`include "falling_sand_grid_update_core_macros.svh"

module falling_sand_grid_update_core
   import fsgu_pkg::*;
#(
   parameter int GRID_WIDTH  = 64,
   parameter int GRID_HEIGHT = 64
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_op,
   input  logic [5:0]         req_column,
   input  logic [5:0]         req_grid_row,
   input  logic [CELL_W-1:0]  req_hue,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CELL_W-1:0]  rsp_cell_value,
   output logic [COUNT_W-1:0] rsp_grain_total,
   output logic               rsp_is_draining,
   output logic               rsp_placed,
   // register port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [PADDR_W-1:0] csr_paddr,
   input  logic [CSR_W-1:0]   csr_pwdata,
   output logic [CSR_W-1:0]   csr_prdata,
   output logic               csr_pready
);

   ctrl_cmd_type       cmd;
   dp_status_type      sts;
   logic               csr_wr;
   logic               rsp_free;
   logic [COUNT_W-1:0] drain_limit_ff;
   logic [SEED_W-1:0]  seed_ff;
   logic               rsp_valid_ff;
   logic [CELL_W-1:0]  cell_value_ff;
   logic [COUNT_W-1:0] grain_total_ff;
   logic               is_draining_ff;
   logic               placed_ff;
   logic [CELL_W-1:0]  dp_value;
   logic [COUNT_W-1:0] dp_count;
   logic               dp_drain;
   logic               dp_placed;

   // register writes complete in the access phase; no wait states
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_limit_ff <= LIMIT_RESET;
         seed_ff        <= SEED_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            CSR_FILL_LIMIT: drain_limit_ff <= csr_pwdata[COUNT_W-1:0];
            CSR_SEED:       seed_ff        <= csr_pwdata;
            default:        seed_ff        <= seed_ff;
         endcase
      end
   end

   // readback shows the written seed, not the running generator state
   always_comb begin
      unique case (csr_paddr[2])
         CSR_FILL_LIMIT: csr_prdata = CSR_W'(drain_limit_ff);
         CSR_SEED:       csr_prdata = seed_ff;
         default:        csr_prdata = '0;
      endcase
   end

   // output register frees the controller as soon as its word is taken
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   fsgu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_free  (rsp_free),
      .sts       (sts),
      .cmd       (cmd)
   );

   fsgu_datapath #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_op       (req_op),
      .req_column   (req_column),
      .req_grid_row (req_grid_row),
      .req_hue      (req_hue),
      .drain_limit  (drain_limit_ff),
      .seed_load    (csr_wr && csr_paddr[2] == CSR_SEED),
      .seed_value   (csr_pwdata),
      .value        (dp_value),
      .count        (dp_count),
      .drain        (dp_drain),
      .placed       (dp_placed)
   );

   // response word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         cell_value_ff  <= dp_value;
         grain_total_ff <= dp_count;
         is_draining_ff <= dp_drain;
         placed_ff      <= dp_placed;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_value  = cell_value_ff;
   assign rsp_grain_total = grain_total_ff;
   assign rsp_is_draining = is_draining_ff;
   assign rsp_placed      = placed_ff;

   // the controller is busy the cycle after it takes a word
   `FSGU_ASSERT_NXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   // a stored grain means the grid cannot be empty and no cell is read back
   `FSGU_ASSERT_IMP(a_placed_count, rsp_valid && rsp_placed, rsp_grain_total != '0)
   `FSGU_ASSERT_IMP(a_placed_no_value, rsp_valid && rsp_placed, rsp_cell_value == '0)

endmodule
